// ===== hdl/idr_pkg.sv =====
// Shared types and action codes for the integer divider.
package idr_pkg;

    // Action bit positions carried in tuser.
    localparam int unsigned ACT_REM_BIT      = 0;
    localparam int unsigned ACT_UNSIGNED_BIT = 1;
    localparam int unsigned ACT_WIDTH        = 2;

    typedef struct packed {
        logic start;
    } core_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

endpackage

// ===== hdl/idr_core.sv =====
// Radix-2 restoring divider core, one quotient bit per cycle.
module idr_core
    import idr_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  core_ctrl_t            ctrl,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output core_stat_t            stat,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic [DATA_WIDTH-1:0] remainder
);

    localparam int unsigned CNT_W = $clog2(DATA_WIDTH + 1);

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [DATA_WIDTH-1:0] div_reg, div_next;

    logic [DATA_WIDTH-1:0] shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  carry;
    logic                  take;

    always_comb begin
        carry   = rem_reg[DATA_WIDTH-1];
        shifted = {rem_reg[DATA_WIDTH-2:0], quo_reg[DATA_WIDTH-1]};
        diff    = {1'b0, shifted} - {1'b0, div_reg};
        take    = carry || !diff[DATA_WIDTH];

        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        if (ctrl.start) begin
            count_next = CNT_W'(DATA_WIDTH);
            rem_next   = '0;
            quo_next   = dividend;
            div_next   = divisor;
        end else if (count_reg != '0) begin
            count_next = count_reg - 1'b1;
            rem_next   = take ? diff[DATA_WIDTH-1:0] : shifted;
            quo_next   = {quo_reg[DATA_WIDTH-2:0], take};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign stat.busy = (count_reg != '0);
    assign stat.done = (count_reg == CNT_W'(1));
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== hdl/int32_divide_remainder.sv =====
// Top level of the signed/unsigned integer divider with stream ports.
// One beat in gives one beat out: the quotient or remainder of dividend by divisor,
// signed or unsigned per tuser. An item goes from the input beat through a step that
// forms operand magnitudes, the shared restoring subtract loop at one quotient bit
// per cycle, and a sign fix-up step before its result is presented.
// Items are handled one at a time; a new beat is taken while a finished result waits.
// Division by zero gives a quotient of zero and a remainder equal to the dividend.
module int32_divide_remainder
    import idr_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // dividend [DATA_WIDTH-1:0], divisor above it, zero pad to bytes
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // action [1:0]
    input  logic [ACT_WIDTH-1:0]   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // result [DATA_WIDTH-1:0], zero pad to bytes
    output logic [((DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

    localparam int unsigned MDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN,
        ST_FIX
    } state_t;

    state_t                state_reg, state_next;
    logic [ACT_WIDTH-1:0]  act_reg, act_next;
    logic [DATA_WIDTH-1:0] a_reg, a_next;
    logic [DATA_WIDTH-1:0] b_reg, b_next;
    logic                  a_neg_reg, a_neg_next;
    logic                  b_neg_reg, b_neg_next;
    logic                  b_zero_reg, b_zero_next;
    logic                  m_valid_reg, m_valid_next;
    logic [DATA_WIDTH-1:0] result_reg, result_next;

    core_ctrl_t            core_ctrl;
    core_stat_t            core_stat;
    logic [DATA_WIDTH-1:0] core_quo;
    logic [DATA_WIDTH-1:0] core_rem;
    logic [DATA_WIDTH-1:0] a_mag;
    logic [DATA_WIDTH-1:0] b_mag;
    logic [DATA_WIDTH-1:0] res_mag;
    logic                  res_neg;
    logic                  in_beat;
    logic                  out_load;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_FIX) && (!m_valid_reg || m_axis_tready);

    always_comb begin
        a_mag = a_neg_reg ? ({DATA_WIDTH{1'b0}} - a_reg) : a_reg;
        b_mag = b_neg_reg ? ({DATA_WIDTH{1'b0}} - b_reg) : b_reg;
        if (act_reg[ACT_REM_BIT]) begin
            res_mag = core_rem;
            res_neg = a_neg_reg;
        end else begin
            res_mag = b_zero_reg ? '0 : core_quo;
            res_neg = a_neg_reg ^ b_neg_reg;
        end
    end

    assign core_ctrl.start = (state_reg == ST_PREP);

    idr_core #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (core_ctrl),
        .dividend  (a_mag),
        .divisor   (b_mag),
        .stat      (core_stat),
        .quotient  (core_quo),
        .remainder (core_rem)
    );

    always_comb begin
        state_next   = state_reg;
        act_next     = act_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        a_neg_next   = a_neg_reg;
        b_neg_next   = b_neg_reg;
        b_zero_next  = b_zero_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        result_next  = result_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    act_next    = s_axis_tuser;
                    a_next      = s_axis_tdata[DATA_WIDTH-1:0];
                    b_next      = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
                    a_neg_next  = !s_axis_tuser[ACT_UNSIGNED_BIT]
                                  && s_axis_tdata[DATA_WIDTH-1];
                    b_neg_next  = !s_axis_tuser[ACT_UNSIGNED_BIT]
                                  && s_axis_tdata[2*DATA_WIDTH-1];
                    b_zero_next = (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH] == '0);
                    state_next  = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (core_stat.done) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                if (out_load) begin
                    result_next  = res_neg ? ({DATA_WIDTH{1'b0}} - res_mag) : res_mag;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        act_reg    <= act_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        a_neg_reg  <= a_neg_next;
        b_neg_reg  <= b_neg_next;
        b_zero_reg <= b_zero_next;
        result_reg <= result_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = MDATA_W'(result_reg);

    a_core_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        core_stat.done |-> (state_reg == ST_RUN))
        else $error("core finished outside run state");

    a_core_busy_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PREP) |=> core_stat.busy && (state_reg == ST_RUN))
        else $error("core not started after prep");

    a_fix_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_axis_tvalid && (state_reg == ST_IDLE))
        else $error("result not presented after fix-up");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIX) && !b_zero_reg |-> (core_rem < b_mag))
        else $error("remainder not below divisor");

    a_zero_div_quotient: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && b_zero_reg && !act_reg[ACT_REM_BIT] |=> (result_reg == '0))
        else $error("nonzero quotient on division by zero");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the 32-bit signed/unsigned restoring divider.
module testbench;
    import idr_pkg::*;

    localparam int unsigned DW = 32;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned CHUNK_ITEMS = 250;
    localparam int unsigned CHUNKS = 7;
    localparam int unsigned SETTLE_CYCLES = 40;

    localparam logic [ACT_WIDTH-1:0] ACT_SDIV = '0;
    localparam logic [ACT_WIDTH-1:0] ACT_SREM = ACT_WIDTH'(1 << ACT_REM_BIT);
    localparam logic [ACT_WIDTH-1:0] ACT_UDIV = ACT_WIDTH'(1 << ACT_UNSIGNED_BIT);
    localparam logic [ACT_WIDTH-1:0] ACT_UREM = ACT_SREM | ACT_UDIV;

    typedef struct {
        logic [ACT_WIDTH-1:0] action;
        logic [DW-1:0]        dividend;
        logic [DW-1:0]        divisor;
    } div_op_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [2*DW-1:0]      s_axis_tdata = '0;
    logic [ACT_WIDTH-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [DW-1:0]        m_axis_tdata;

    div_op_t       operand_queue[$];
    logic [DW-1:0] results_due[$];
    int unsigned   outstanding = 0;
    int unsigned   mismatches = 0;
    int unsigned   send_gap = 0;
    int unsigned   stall_left = 0;
    int unsigned   quiet_cycles = 0;
    bit            idle_on = 1'b1;

    int32_divide_remainder uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic logic [DW-1:0] compute_div_result(logic [ACT_WIDTH-1:0] act,
                                                         logic [DW-1:0] a, logic [DW-1:0] b);
        logic          is_signed;
        logic          a_neg;
        logic          b_neg;
        logic [DW-1:0] ma;
        logic [DW-1:0] mb;
        logic [DW-1:0] q;
        logic [DW-1:0] r;
        is_signed = !act[ACT_UNSIGNED_BIT];
        a_neg = is_signed && a[DW-1];
        b_neg = is_signed && b[DW-1];
        ma = a_neg ? DW'(-a) : a;
        mb = b_neg ? DW'(-b) : b;
        if (mb == '0) begin
            q = '0;
            r = ma;
        end else begin
            q = ma / mb;
            r = ma % mb;
        end
        if (act[ACT_REM_BIT])
            return a_neg ? DW'(-r) : r;
        return (a_neg ^ b_neg) ? DW'(-q) : q;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [DW-1:0] rand_operand();
        logic [DW-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0: v = '0;
                    1: v = 1;
                    2: v = '1;
                    3: v = {1'b1, {(DW-1){1'b0}}};
                    4: v = {1'b0, {(DW-1){1'b1}}};
                    default: v = {{(DW-1){1'b1}}, 1'b0};
                endcase
            end
            1, 2: begin
                v = $urandom_range(0, 15);
                if ($urandom_range(0, 1) != 0)
                    v = -v;
            end
            3, 4, 5: begin
                v = $urandom >> $urandom_range(1, DW-1);
                if ($urandom_range(0, 1) != 0)
                    v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic queue_op(logic [ACT_WIDTH-1:0] act, logic [DW-1:0] a, logic [DW-1:0] b);
        div_op_t op;
        op.action = act;
        op.dividend = a;
        op.divisor = b;
        operand_queue.push_back(op);
    endtask

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (operand_queue.size() != 0 || s_axis_tvalid || outstanding != 0);
    endtask

    initial begin
        forever #1 aclk = ~aclk;
    end

    // driver
    always @(posedge aclk) begin
        div_op_t op;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (operand_queue.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                op = operand_queue.pop_front();
                s_axis_tdata <= {op.divisor, op.dividend};
                s_axis_tuser <= op.action;
                s_axis_tvalid <= 1'b1;
                send_gap <= pick_gap();
            end
        end
    end

    // monitor and receiver backpressure
    always @(posedge aclk) begin
        logic [DW-1:0] want;
        bit            took_in;
        bit            took_out;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
            outstanding <= 0;
        end else begin
            took_in = s_axis_tvalid && s_axis_tready;
            took_out = m_axis_tvalid && m_axis_tready;
            if (took_in)
                results_due.push_back(compute_div_result(s_axis_tuser,
                                                         s_axis_tdata[DW-1:0],
                                                         s_axis_tdata[2*DW-1:DW]));
            if (took_out) begin
                if (results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, m_axis_tdata);
                end else begin
                    want = results_due.pop_front();
                    if (m_axis_tdata !== want) begin
                        mismatches++;
                        $display("%0t: result mismatch, expected %h, actual %h",
                                 $time, want, m_axis_tdata);
                    end
                end
            end
            outstanding <= outstanding + took_in - (took_out && outstanding != 0);
            if (stall_left != 0) begin
                m_axis_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left <= pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [ACT_WIDTH-1:0] acts[4];
        logic [DW-1:0]        dvd[6];
        logic [DW-1:0]        dvs[6];
        acts = '{ACT_SDIV, ACT_SREM, ACT_UDIV, ACT_UREM};
        dvd = '{32'h8000_0000, 32'h8765_4321, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFF9};
        dvs = '{32'hFFFF_FFFF, 32'h0, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h2};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < 6; i++)
            foreach (acts[k])
                queue_op(acts[k], dvd[i], dvs[i]);
        wait_drained();

        // drain between chunks; run some chunks with beats back to back and no idling
        for (int c = 0; c < CHUNKS; c++) begin
            idle_on = (c % 3) != 2;
            for (int i = 0; i < CHUNK_ITEMS; i++)
                queue_op(ACT_WIDTH'($urandom_range(0, 3)), rand_operand(),
                         ($urandom_range(0, 19) == 0) ? '0 : rand_operand());
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (results_due.size() != 0) begin
            mismatches++;
            $display("%0t: %0d results never arrived, expected %h, actual none",
                     $time, results_due.size(), results_due[0]);
        end
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
